FILE: hw/rtl/bpfs_pkg.sv
package bpfs_pkg;

  // Time base width
  localparam int unsigned TimeW = 32;
  typedef logic [TimeW-1:0] tstamp_t;

  // Configuration register widths
  localparam int unsigned PreW   = 15;
  localparam int unsigned FlushW = 16;
  localparam int unsigned TmoW   = 24;
  localparam int unsigned CfgW   = 24;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PREINF  = 2'd0,
    CFG_FLUSH   = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_e;

  // Preinfusion phase codes
  typedef enum logic [1:0] {
    PH_MAIN   = 2'd0,
    PH_PREINF = 2'd1,
    PH_BLOOM  = 2'd2
  } phase_e;

  // Limits
  localparam logic [PreW-1:0]   PreinfMinMs  = 15'd50;
  localparam logic [PreW-1:0]   PreinfMaxMs  = 15'd30000;
  localparam logic [TmoW-1:0]   TimeoutMaxMs = 24'd14400000;
  localparam logic [FlushW-1:0] FlushResetMs = 16'd3000;

endpackage

FILE: hw/rtl/brew_pump_flush_sequencer.sv
// A word accepted into the input register goes to the result register when that
// is free: one word per cycle while the output does not stall. While a result word
// is stalled the input register takes one more word; then the input stalls.
// The tick logic sits between the input register and the state/result registers.
// Reset (rst_ni low, asynchronous): no words held, shot and flush idle,
// heater allowed, flush length 3000 ms, preinfusion and timeout 0.
module brew_pump_flush_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [bpfs_pkg::CfgW-1:0]   cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpfs_pkg::tstamp_t           now_ms_i,
  input  logic                        brew_request_i,
  input  logic                        brew_changed_i,
  input  logic                        flush_start_i,
  input  logic                        flush_stop_i,
  input  logic                        heater_write_i,
  input  logic                        heater_value_i,
  input  logic                        activity_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        pump_on_o,
  output logic                        relief_open_o,
  output logic                        brewing_o,
  output logic [1:0]                  preinfusion_phase_o,
  output logic                        heater_enabled_o,
  output logic                        heater_timed_out_o,
  output bpfs_pkg::tstamp_t           shot_elapsed_ms_o,
  output logic [bpfs_pkg::FlushW-1:0] flush_remaining_ms_o
);
  import bpfs_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [PreW-1:0]   pre_cfg_q;
  logic [FlushW-1:0] flush_cfg_q;
  logic [TmoW-1:0]   tmo_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cfg_q   <= '0;
      flush_cfg_q <= FlushResetMs;
      tmo_cfg_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PREINF:  pre_cfg_q   <= cfg_data_i[PreW-1:0];
        CFG_FLUSH:   flush_cfg_q <= cfg_data_i[FlushW-1:0];
        CFG_TIMEOUT: tmo_cfg_q   <= cfg_data_i[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped settings
  logic [PreW-1:0] pre_lim;
  logic [TmoW-1:0] tmo_lim;
  assign pre_lim = (pre_cfg_q > PreinfMaxMs) ? PreinfMaxMs : pre_cfg_q;
  assign tmo_lim = (tmo_cfg_q > TimeoutMaxMs) ? TimeoutMaxMs : tmo_cfg_q;

  // ---------------------------------------------------------------
  // Handshake control
  logic s1_vld_q, out_vld_q;
  logic in_acc, s2_go;

  assign s2_go      = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s2_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s2_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s2_go) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input register
  tstamp_t s1_now_q;
  logic    s1_req_q, s1_bchg_q, s1_fstart_q, s1_fstop_q;
  logic    s1_hwr_q, s1_hval_q, s1_act_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_now_q    <= now_ms_i;
      s1_req_q    <= brew_request_i;
      s1_bchg_q   <= brew_changed_i;
      s1_fstart_q <= flush_start_i;
      s1_fstop_q  <= flush_stop_i;
      s1_hwr_q    <= heater_write_i;
      s1_hval_q   <= heater_value_i;
      s1_act_q    <= activity_i;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer state
  logic    brew_q, brew_d;
  phase_e  phase_q, phase_d;
  tstamp_t phase_start_q, phase_start_d;
  tstamp_t shot_start_q, shot_start_d;
  logic    flush_q, flush_d;
  tstamp_t flush_dl_q, flush_dl_d;
  tstamp_t last_act_q, last_act_d;
  logic    act_pend_q, act_pend_d;
  logic    heat_q, heat_d;

  // Tick intermediates
  logic    fl_start_ok, act_mark;
  logic    fl_arm;
  tstamp_t fl_dl_arm;
  logic    heat_req;
  logic    brew_new;
  phase_e  phase_new;
  tstamp_t phase_start_new;
  tstamp_t phase_el;
  tstamp_t fl_left;
  logic    fl_expired;
  tstamp_t idle_el;
  logic    timed_out;
  tstamp_t shot_el;
  logic [FlushW-1:0] remain;

  always_comb begin
    // operator requests
    fl_start_ok = s1_fstart_q && !brew_q;
    act_mark    = act_pend_q || s1_bchg_q || fl_start_ok || s1_hwr_q || s1_act_q;

    fl_arm    = flush_q;
    fl_dl_arm = flush_dl_q;
    if (fl_start_ok) begin
      fl_arm    = 1'b1;
      fl_dl_arm = s1_now_q + TimeW'(flush_cfg_q);
    end
    if (s1_fstop_q) begin
      fl_arm    = 1'b0;
      fl_dl_arm = '0;
    end
    heat_req = s1_hwr_q ? s1_hval_q : heat_q;

    // brew switch
    brew_new        = brew_q;
    phase_new       = phase_q;
    phase_start_new = phase_start_q;
    shot_start_d    = shot_start_q;
    if (s1_req_q && !brew_q) begin
      brew_new        = 1'b1;
      shot_start_d    = s1_now_q;
      phase_new       = (pre_lim >= PreinfMinMs) ? PH_PREINF : PH_MAIN;
      phase_start_new = s1_now_q;
    end else if (!s1_req_q && brew_q) begin
      brew_new  = 1'b0;
      phase_new = PH_MAIN;
    end

    // preinfusion phase advance
    phase_el      = s1_now_q - phase_start_new;
    phase_d       = phase_new;
    phase_start_d = phase_start_new;
    if (brew_new && (phase_el >= TimeW'(pre_lim))) begin
      case (phase_new)
        PH_PREINF: begin
          phase_d       = PH_BLOOM;
          phase_start_d = s1_now_q;
        end
        PH_BLOOM: begin
          phase_d       = PH_MAIN;
          phase_start_d = s1_now_q;
        end
        default: ;
      endcase
    end
    brew_d = brew_new;

    // flush expiry: signed distance to deadline is zero or negative
    fl_left    = fl_dl_arm - s1_now_q;
    fl_expired = (fl_left == '0) || fl_left[TimeW-1];
    flush_d    = fl_arm;
    flush_dl_d = fl_dl_arm;
    if (fl_arm && (brew_new || fl_expired)) begin
      flush_d    = 1'b0;
      flush_dl_d = '0;
    end

    // inactivity timeout
    last_act_d = (act_mark || brew_new) ? s1_now_q : last_act_q;
    act_pend_d = 1'b0;
    idle_el    = (act_mark || brew_new) ? '0 : (s1_now_q - last_act_q);
    timed_out  = (tmo_lim != '0) && heat_req && (idle_el >= TimeW'(tmo_lim));
    heat_d     = heat_req && !timed_out;

    // reported times
    shot_el = brew_new ? (s1_now_q - shot_start_d) : '0;
    if (flush_d) begin
      remain = (|fl_left[TimeW-1:FlushW]) ? '1 : fl_left[FlushW-1:0];
    end else begin
      remain = '0;
    end
  end

  // State update, one tick per word moved to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brew_q        <= 1'b0;
      phase_q       <= PH_MAIN;
      phase_start_q <= '0;
      shot_start_q  <= '0;
      flush_q       <= 1'b0;
      flush_dl_q    <= '0;
      last_act_q    <= '0;
      act_pend_q    <= 1'b1;
      heat_q        <= 1'b1;
    end else if (s2_go) begin
      brew_q        <= brew_d;
      phase_q       <= phase_d;
      phase_start_q <= phase_start_d;
      shot_start_q  <= shot_start_d;
      flush_q       <= flush_d;
      flush_dl_q    <= flush_dl_d;
      last_act_q    <= last_act_d;
      act_pend_q    <= act_pend_d;
      heat_q        <= heat_d;
    end
  end

  // Result register
  logic              pump_q, relief_q, brewing_q, heat_out_q, tmo_out_q;
  logic [1:0]        phase_out_q;
  tstamp_t           shot_el_q;
  logic [FlushW-1:0] remain_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      pump_q      <= (brew_d && (phase_d != PH_BLOOM)) || flush_d;
      relief_q    <= !brew_d && !flush_d;
      brewing_q   <= brew_d;
      phase_out_q <= phase_d;
      heat_out_q  <= heat_d;
      tmo_out_q   <= timed_out;
      shot_el_q   <= shot_el;
      remain_q    <= remain;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign pump_on_o            = pump_q;
  assign relief_open_o        = relief_q;
  assign brewing_o            = brewing_q;
  assign preinfusion_phase_o  = phase_out_q;
  assign heater_enabled_o     = heat_out_q;
  assign heater_timed_out_o   = tmo_out_q;
  assign shot_elapsed_ms_o    = shot_el_q;
  assign flush_remaining_ms_o = remain_q;

`ifndef SYNTHESIS
  // pump and relief valve never both driven open
  a_pump_relief_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pump_on_o && relief_open_o))
    else $error("pump on with relief open");

  // idle shot reports no phase and no elapsed time
  a_idle_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !brewing_o) |-> (preinfusion_phase_o == PH_MAIN) &&
    (shot_elapsed_ms_o == '0))
    else $error("phase or shot time while not brewing");

  // a timeout cut leaves the heater off
  a_timeout_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && heater_timed_out_o) |-> !heater_enabled_o)
    else $error("heater on after timeout");

  // no preinfusion phase without an active shot
  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !brew_q |-> (phase_q == PH_MAIN))
    else $error("phase active without shot");
`endif

endmodule
